/* rtl/byte_list_engine_unit_defines.svh */
// assertion macros for the byte list engine
// used by byte_list_engine_unit, relies on clk and arst_n in scope
`ifndef BYTE_LIST_ENGINE_UNIT_DEFINES_SVH
`define BYTE_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ble_pkg.sv */
// shared types and constants for the byte list engine
// no dependencies
package ble_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CMD_W        = 3;
	localparam int VAL_W        = 8;
	localparam int STAT_W       = 2;
	localparam int CNT_OUT_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ORDERED = 3'd0,
		CMD_APPEND  = 3'd1,
		CMD_PUSH    = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_POP     = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REPORT
	} state_t;

endpackage

/* rtl/ble_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ble_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/byte_list_engine_unit.sv */
// byte list engine: ordered list of bytes in a ram, one walk per insert or remove that is not refused
// done follows the ram walk for walking commands, and comes in the cycle after accept otherwise
// a new command is accepted only while idle, so one command is in flight at a time (ram walk)
// the walk reads one entry per cycle through the single registered read port
// reset clears the fill count and the sequencer; ram contents stay undefined
// done is a one-cycle strobe, the receiver cannot stall it
module byte_list_engine_unit
	import ble_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [VAL_W-1:0]     value,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [VAL_W-1:0]     removed_value,
	output logic                 is_empty,
	output logic [CNT_OUT_W-1:0] entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// sequencer and datapath registers
	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] carry_q;    // word displaced by an insert, moves toward the tail
	logic [VAL_W-1:0] removed_q;
	logic             hit_q;      // insert point or match already passed
	logic [CW-1:0]    pos_q;      // position whose word is on rd_data
	logic [CW-1:0]    count_q;
	status_t          status_q;

	// ram port signals
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	// decode of the accepted word
	logic  accept;
	cmd_t  cmd_in;
	logic  in_insert, in_remove, full, empty;
	logic  scan_insert, at_tail, ins_hit, rem_hit;

	assign accept = start && !busy;
	assign cmd_in = cmd_t'(command);
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	assign in_insert = (cmd_in == CMD_ORDERED) || (cmd_in == CMD_APPEND)
	                || (cmd_in == CMD_PUSH);
	assign in_remove = (cmd_in == CMD_REMOVE) || (cmd_in == CMD_POP);

	assign scan_insert = (cmd_q == CMD_ORDERED) || (cmd_q == CMD_APPEND)
	                  || (cmd_q == CMD_PUSH);
	assign at_tail     = (pos_q == count_q);

	// insert point: ordered stops at the first word not smaller, push at the head,
	// append never hits and lands at the tail
	always_comb begin
		unique case (cmd_q)
			CMD_ORDERED: ins_hit = (rd_data >= val_q);
			CMD_PUSH:    ins_hit = 1'b1;
			default:     ins_hit = 1'b0;
		endcase
	end

	// pop takes the head, remove takes the first equal word
	assign rem_hit = (cmd_q == CMD_POP) || (rd_data == val_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((in_insert && !full) || (in_remove && !empty)) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_REPORT;
					end
				end
			end
			S_SCAN: begin
				if (at_tail) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(pos_q);
		wr_data = carry_q;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_addr = AW'(pos_q + CW'(1));
				if (scan_insert) begin
					if (at_tail) begin
						// last slot takes the carried word, or the new one if no hit
						wr_en   = 1'b1;
						wr_data = hit_q ? carry_q : val_q;
					end else if (hit_q) begin
						wr_en   = 1'b1;
						wr_data = carry_q;
					end else if (ins_hit) begin
						wr_en   = 1'b1;
						wr_data = val_q;
					end
				end else if (!at_tail && hit_q) begin
					// close the gap: each later word moves one toward the head
					wr_en   = 1'b1;
					wr_addr = AW'(pos_q - CW'(1));
					wr_data = rd_data;
				end
			end
			S_REPORT: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_REPORT);
	assign status        = status_q;
	assign removed_value = removed_q;
	assign is_empty      = empty;
	assign entry_count   = CNT_OUT_W'(count_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN && at_tail) begin
				if (scan_insert) begin
					count_q <= count_q + CW'(1);
				end else if (hit_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cmd_q     <= cmd_in;
			val_q     <= value;
			pos_q     <= '0;
			hit_q     <= 1'b0;
			removed_q <= '0;
			if (in_insert && full) begin
				status_q <= STAT_FULL;
			end else if (in_remove && empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_DONE;
			end
		end else if (state_q == S_SCAN) begin
			if (!at_tail) begin
				pos_q <= pos_q + CW'(1);
				if (scan_insert) begin
					if (hit_q || ins_hit) begin
						carry_q <= rd_data;
						hit_q   <= 1'b1;
					end
				end else if (!hit_q && rem_hit) begin
					hit_q     <= 1'b1;
					removed_q <= rd_data;
				end
			end else if (!scan_insert && !hit_q) begin
				status_q <= STAT_NOT_FOUND;
			end
		end
	end

	ble_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

`include "byte_list_engine_unit_defines.svh"

	// a result is followed by a free block
	`BLE_ASSERT_NEXT(a_done_frees, done, !busy, "busy still set after done")
	// the fill count never passes the capacity
	`BLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count overflow")
	// the count moves only as a result is shown
	`BLE_ASSERT_NOW(a_count_at_report, !$stable(count_q), state_q == S_REPORT, "count moved mid walk")
	// insert into a full list is refused at once
	`BLE_ASSERT_NEXT(a_full_refuse, accept && full && in_insert, done && status == STAT_FULL, "full insert not refused")

endmodule
